/* hw/rtl/sti_pkg.sv */
// Shared constants, types and codes for the sorted table interpolator.
// Used by the interface, the cell, the divider and the top level.
`default_nettype none
package sti_pkg;
  localparam int TableDepth = 16;
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int AngleW = 15;
  localparam int WeightW = 16;
  localparam int NumW = 32;
  localparam int DenW = AngleW + WeightW;
  localparam int DivW = NumW + 15;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               clear;
    logic               insert;
    logic [AngleW-1:0]  angle;
    logic [WeightW-1:0] weight;
  } cell_ctl_t;

  // One point as stored in a cell.
  typedef struct packed {
    logic [AngleW-1:0]  angle;
    logic [WeightW-1:0] weight;
  } point_t;
endpackage
`default_nettype wire

/* hw/rtl/sti_if.sv */
// Valid/ready channel interface for the interpolator items.
// Depends on sti_pkg.
`default_nettype none
interface sti_in_if import sti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] angle_in;
  logic [15:0]        weight_in;
  modport source(output valid, operation, angle_in, weight_in, input ready);
  modport sink(input valid, operation, angle_in, weight_in, output ready);
endinterface

interface sti_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] weight_out;
  logic [1:0]  status;
  modport source(output valid, weight_out, status, input ready);
  modport sink(input valid, weight_out, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sti_cell.sv */
// One table cell: holds a point and a valid bit, shifts on insert.
// Depends on sti_pkg.
`default_nettype none
module sti_cell import sti_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire logic      left_valid,
  input  wire logic      left_goes,
  input  wire point_t    left_point,
  output logic           valid,
  output logic           goes,
  output point_t         point
);
  // goes: new point belongs at or before this cell (sorted order).
  always_comb begin
    goes = !valid || (point.angle > ctl.angle) ||
           (point.angle == ctl.angle && point.weight > ctl.weight);
  end

  // Left neighbor shifting too: take its point; otherwise this is the slot.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert && goes) begin
      valid <= valid || left_valid;
      if (left_goes && left_valid) begin
        point <= left_point;
      end else begin
        point <= '{angle: ctl.angle, weight: ctl.weight};
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sti_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on sti_pkg.
`default_nettype none
module sti_div import sti_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DivW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [DivW-1:0]      quo
);
  localparam int CntW = $clog2(DivW + 1);
  logic [DenW:0]   rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  always_comb trial = {rem[DenW-1:0], quo[DivW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      quo  <= num;
      dreg <= den;
      cnt  <= CntW'(DivW);
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DivW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/sorted_table_interpolator_core.sv */
// Top level: sorted angle/weight table with linear interpolation.
// Depends on sti_pkg, sti_if, sti_cell, sti_div.
//
//  channel | dir | payload
//  in_ch   | in  | operation, angle_in, weight_in
//  out_ch  | out | weight_out, status
//
// Clear, insert, no-op and early-status samples: the cell row shifts at the
// accept edge, then the core passes through S_OUT and raises the result.
// A full sample: the S_FIND scan over the stored cells, the S_MUL multiply,
// the divider load, the restoring divide, taking the quotient and raising
// the result in S_OUT.
// One item is in work at a time; the result register holds while out_ch
// stalls and the next item is taken once it is free.
// Reset (rst, synchronous) empties the table; no clearing pass.
`default_nettype none
module sorted_table_interpolator_core import sti_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  sti_in_if.sink   in_ch,
  sti_out_if.source out_ch
);
  state_t state, state_next;
  cell_ctl_t ctl;
  logic [TableDepth-1:0] cvalid, cgoes;
  point_t cpoint [TableDepth];
  logic [CountW-1:0] count;
  logic [WeightW-1:0] maxw;

  logic [AngleW-1:0] a, a_in;
  logic [IdxW-1:0] idx;
  logic [CountW-1:0] scan;
  point_t p0, p1;
  logic kind; // 1: end or single-point value, 0: interpolate
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic div_start, div_done;
  logic [DivW-1:0] quo;
  logic [15:0] res;
  logic [1:0] st;
  status_t st_next;
  logic accept;

  // |angle|, most negative saturates.
  logic [15:0] mag;
  always_comb begin
    mag = in_ch.angle_in[15] ? (16'd0 - in_ch.angle_in) : in_ch.angle_in;
    a_in = mag[15] ? {AngleW{1'b1}} : mag[AngleW-1:0];
  end

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    ctl.clear = accept && op_t'(in_ch.operation) == OP_CLEAR;
    ctl.insert = accept && op_t'(in_ch.operation) == OP_INSERT &&
                 count < CountW'(TableDepth);
    ctl.angle = a_in;
    ctl.weight = in_ch.weight_in;
  end

  // First cell sees a left neighbor that is valid and stays put.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    if (g == 0) begin : g_first
      sti_cell u_cell (.clk, .rst, .ctl, .left_valid(1'b1), .left_goes(1'b0),
        .left_point(cpoint[0]), .valid(cvalid[g]), .goes(cgoes[g]),
        .point(cpoint[g]));
    end else begin : g_rest
      sti_cell u_cell (.clk, .rst, .ctl, .left_valid(cvalid[g-1]),
        .left_goes(cgoes[g-1]), .left_point(cpoint[g-1]),
        .valid(cvalid[g]), .goes(cgoes[g]), .point(cpoint[g]));
    end
  end

  sti_div u_div (.clk, .rst, .start(div_start), .num({num, 15'd0}), .den,
    .done(div_done), .quo);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = (op_t'(in_ch.operation) == OP_SAMPLE &&
                count != '0 && maxw != '0) ? S_FIND : S_OUT;
      S_FIND: if (scan == count) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Status known at accept time.
  always_comb begin
    st_next = ST_OK;
    unique case (op_t'(in_ch.operation))
      OP_INSERT: if (count >= CountW'(TableDepth)) st_next = ST_FULL;
      OP_SAMPLE: if (count == '0) st_next = ST_EMPTY;
                 else if (maxw == '0) st_next = ST_ZERO;
      default: st_next = ST_OK;
    endcase
  end

  logic [AngleW-1:0] dx;
  always_comb dx = p1.angle - p0.angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      maxw <= '0;
      out_ch.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      // Divider loads the cycle after S_MUL, once num/den are registered.
      div_start <= (state == S_MUL);
      if (state == S_OUT) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (ctl.clear) begin
        count <= '0;
        maxw <= '0;
      end
      if (ctl.insert) begin
        count <= count + 1'b1;
        if (in_ch.weight_in > maxw) maxw <= in_ch.weight_in;
      end
    end
  end

  // Datapath; scan walks cells with one fixed compare per step.
  always_ff @(posedge clk) begin
    if (accept) begin
      a <= a_in;
      scan <= CountW'(1);
      idx <= '0;
      res <= '0;
      st <= st_next;
    end
    if (state == S_FIND && scan != count) begin
      // cell index scan is < count; advance i while x[i+1] <= a, i+1 < n-1
      if (scan + 1'b1 < count && cpoint[scan[IdxW-1:0]].angle <= a)
        idx <= scan[IdxW-1:0];
      scan <= scan + 1'b1;
    end
    if (state == S_FIND && scan == count) begin
      if (a < cpoint[0].angle) begin
        kind <= 1'b1; p0 <= cpoint[0];
      end else if (a > cpoint[IdxW'(count - 1'b1)].angle) begin
        kind <= 1'b1; p0 <= cpoint[IdxW'(count - 1'b1)];
      end else if (count == CountW'(1)) begin
        kind <= 1'b1; p0 <= cpoint[0];
      end else begin
        kind <= 1'b0; p0 <= cpoint[idx]; p1 <= cpoint[idx + 1'b1];
      end
    end
    if (state == S_MUL) begin
      if (kind || dx == '0) begin
        num <= NumW'(p0.weight);
        den <= DenW'(maxw);
      end else begin
        num <= NumW'(p0.weight) * NumW'(p1.angle - a) +
               NumW'(p1.weight) * NumW'(a - p0.angle);
        den <= DenW'(dx) * DenW'(maxw);
      end
    end
    if (state == S_DIV && div_done)
      res <= (quo > DivW'(32768)) ? 16'd32768 : quo[15:0];
  end

  assign out_ch.weight_out = res;
  assign out_ch.status = st;

  assert property (@(posedge clk) disable iff (rst) accept |=> !in_ch.ready)
    else $error("took item while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) count <= CountW'(TableDepth))
    else $error("count overflow");
endmodule
`default_nettype wire

/* dv/sorted_table_interpolator_core_tb.sv */
// Testbench for sorted_table_interpolator_core: a directed table, then random clears,
// inserts and samples, with both channels idling at random.
// Depends on sti_pkg, sti_if and the RTL of the core.
`timescale 1ns / 100ps
`default_nettype none
module sorted_table_interpolator_core_tb;
  import sti_pkg::*;

  logic clk;
  logic rst;
  sti_in_if  in_ch ();
  sti_out_if out_ch ();

  sorted_table_interpolator_core u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Table shadow
  logic [AngleW-1:0]  tbl_angle [TableDepth];
  logic [WeightW-1:0] tbl_weight[TableDepth];
  int unsigned        tbl_count;
  logic [WeightW-1:0] tbl_max;

  typedef struct packed {
    logic [15:0] weight;
    status_t     status;
  } outcome_t;
  outcome_t pending_q[$];

  int errors, cycles, items_sent, results_seen, samples_seen;
  bit quiet_in, quiet_out;   // stretches with no idling

  task automatic report(input string what, input outcome_t got, input outcome_t want);
    errors++;
    $display("ERR %0s: weight %0d/%0d status %0d/%0d", what,
             got.weight, want.weight, got.status, want.status);
  endtask

  function automatic logic [15:0] scale_weight(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    if (den == 0) return 16'd0;
    q = (num * 32768) / den;
    return (q > 32768) ? 16'd32768 : q[15:0];
  endfunction

  // Updates the shadow table and returns the expected outcome.
  function automatic outcome_t predict_outcome(input op_t op, input logic signed [15:0] ang,
                                               input logic [15:0] w);
    outcome_t r;
    int unsigned a, pos, i, x0, x1, y0, y1;
    longint unsigned num;
    r.weight = '0;
    r.status = ST_OK;
    a = (ang < 0) ? -int'(ang) : int'(ang);
    if (a > 32767) a = 32767;
    case (op)
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_max = '0;
      end
      OP_INSERT: begin
        if (tbl_count >= TableDepth) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < tbl_count && (tbl_angle[pos] < a ||
                 (tbl_angle[pos] == a && tbl_weight[pos] <= w))) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_angle[i] = tbl_angle[i-1];
            tbl_weight[i] = tbl_weight[i-1];
          end
          tbl_angle[pos] = AngleW'(a);
          tbl_weight[pos] = w;
          tbl_count++;
          if (w > tbl_max) tbl_max = w;
        end
      end
      OP_SAMPLE: begin
        if (tbl_count == 0) r.status = ST_EMPTY;
        else if (tbl_max == 0) r.status = ST_ZERO;
        else if (a < tbl_angle[0])
          r.weight = scale_weight(64'(tbl_weight[0]), 64'(tbl_max));
        else if (a > tbl_angle[tbl_count-1])
          r.weight = scale_weight(64'(tbl_weight[tbl_count-1]), 64'(tbl_max));
        else begin
          i = 0;
          if (tbl_count >= 2)
            while (i + 1 < tbl_count - 1 && tbl_angle[i+1] <= a) i++;
          x0 = 32'(tbl_angle[i]);
          y0 = 32'(tbl_weight[i]);
          x1 = (tbl_count >= 2) ? 32'(tbl_angle[i+1]) : x0;
          y1 = (tbl_count >= 2) ? 32'(tbl_weight[i+1]) : y0;
          if (x1 == x0) r.weight = scale_weight(64'(y0), 64'(tbl_max));
          else begin
            num = 64'(y0) * 64'(x1 - a) + 64'(y1) * 64'(a - x0);
            r.weight = scale_weight(num, 64'(x1 - x0) * 64'(tbl_max));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one item; a known expectation overrides the prediction when flagged.
  task automatic send_item(input op_t op, input logic signed [15:0] ang,
                           input logic [15:0] w, input bit known, input outcome_t typed);
    outcome_t p;
    while (!quiet_in && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.angle_in <= ang;
    in_ch.weight_in <= w;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_outcome(op, ang, w);
    if (known && p != typed) report("typed row", p, typed);
    pending_q = {pending_q, (known ? typed : p)};
    items_sent++;
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      outcome_t got;
      got.weight = out_ch.weight_out;
      got.status = status_t'(out_ch.status);
      results_seen++;
      if (pending_q.size() == 0) report("unexpected", got, got);
      else begin
        if (got != pending_q[0]) report("mismatch", got, pending_q[0]);
        pending_q.pop_front();
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= quiet_out || ($urandom_range(99) >= 38);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  typedef struct {
    op_t op; logic signed [15:0] ang; logic [15:0] w; bit known; outcome_t want;
  } row_t;
  row_t dir_rows[$];

  task automatic add_row(input op_t op, input int ang, input int w,
                         input bit known = 0, input int ow = 0, input status_t st = ST_OK);
    row_t r;
    r.op = op; r.ang = 16'(ang); r.w = 16'(w); r.known = known;
    r.want.weight = 16'(ow); r.want.status = st;
    dir_rows = {dir_rows, r};
  endtask

  initial begin
    int k, n, set_size;
    logic signed [15:0] ra;
    outcome_t none;
    none = '0;
    tbl_count = 0; tbl_max = '0;
    in_ch.valid = 0; in_ch.operation = OP_CLEAR; in_ch.angle_in = '0; in_ch.weight_in = '0;
    out_ch.ready = 0;
    quiet_in = 0; quiet_out = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed rows: empty, all-zero weights, extremes, duplicates, full, no-op.
    add_row(OP_SAMPLE, 0, 0, 1, 0, ST_EMPTY);
    add_row(OP_INSERT, -32768, 0, 1, 0, ST_OK);      // saturated angle
    add_row(OP_SAMPLE, 100, 0, 1, 0, ST_ZERO);
    add_row(OP_INSERT, 1000, 65535, 1, 0, ST_OK);
    add_row(OP_SAMPLE, 5, 0, 1, 32768, ST_OK);        // below first point
    add_row(OP_SAMPLE, -32768, 0, 1, 0, ST_OK);       // top end weight 0
    add_row(OP_SAMPLE, 20000, 0);
    add_row(OP_NONE, 1234, 4321, 1, 0, ST_OK);
    add_row(OP_CLEAR, 0, 0, 1, 0, ST_OK);
    add_row(OP_INSERT, 500, 300, 1, 0, ST_OK);
    add_row(OP_SAMPLE, -500, 0, 1, 32768, ST_OK);     // single point
    add_row(OP_INSERT, 500, 100);
    add_row(OP_INSERT, 32767, 65535);
    add_row(OP_INSERT, 32767, 1);                     // duplicate at top end
    add_row(OP_SAMPLE, 32767, 0);
    add_row(OP_SAMPLE, 16000, 0);
    add_row(OP_SAMPLE, 500, 0);
    for (k = 0; k < 13; k++) add_row(OP_INSERT, k * 2000 + 1, k * 5000);
    add_row(OP_INSERT, 7, 7, 1, 0, ST_FULL);
    add_row(OP_SAMPLE, 9001, 0);
    add_row(OP_CLEAR, 0, 0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].ang, dir_rows[i].w,
                dir_rows[i].known, dir_rows[i].want);

    // Random: build small tables, then sample them; some noise items mixed in.
    n = 0;
    while (n < 1500) begin
      quiet_in = (n >= 600 && n < 800);
      quiet_out = quiet_in;
      send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 0, none);
      set_size = ($urandom_range(9) == 0) ? $urandom_range(TableDepth + 2)
                                           : $urandom_range(1, 5);
      for (k = 0; k < set_size; k++) begin
        ra = ($urandom_range(7) == 0) ? 16'((k & 1) ? -32768 : 32767)
                                      : 16'($urandom);
        send_item(OP_INSERT, ra,
                  ($urandom_range(9) == 0) ? 16'($urandom_range(1)) : 16'($urandom),
                  0, none);
        n++;
      end
      for (k = $urandom_range(1, 6); k > 0; k--) begin
        send_item(($urandom_range(19) == 0) ? OP_NONE : OP_SAMPLE,
                  16'($urandom), 16'($urandom), 0, none);
        n++;
        samples_seen++;
      end
      n++;
    end
    in_ch.valid <= 1'b0;

    quiet_out = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d items (%0d samples or no-ops), checked %0d results.",
             items_sent, samples_seen, results_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

/* sorted_table_interpolator_core.f */
hw/rtl/sti_pkg.sv
hw/rtl/sti_if.sv
hw/rtl/sti_cell.sv
hw/rtl/sti_div.sv
hw/rtl/sorted_table_interpolator_core.sv
dv/sorted_table_interpolator_core_tb.sv
